@@ hw/rtl/dltq_pkg.sv @@
`timescale 1ns / 1ps
package dltq_pkg;

	localparam int SLOTS_DEF = 16;

	localparam logic [1:0] ACT_ADD      = 2'd0;
	localparam logic [1:0] ACT_TICK     = 2'd1;
	localparam logic [1:0] ACT_DISPATCH = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_INS,
		OP_TICK,
		OP_POP
	} op_t;

	// one queue entry; due holds the ticks left counted from now
	typedef struct packed {
		logic        valid;
		logic        rdy;
		logic [7:0]  task_id;
		logic [15:0] period;
		logic [15:0] due;
	} entry_t;

	typedef struct packed {
		op_t         op;
		logic        dec;
		logic [7:0]  task_id;
		logic [15:0] period;
		logic [15:0] delay;
	} cmd_t;

endpackage

@@ hw/rtl/dltq_cell.sv @@
`timescale 1ns / 1ps
module dltq_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  dltq_pkg::cmd_t    cmd,
	input  dltq_pkg::entry_t  left,
	input  dltq_pkg::entry_t  right,
	input  logic              prev_keep,
	input  logic              prev_rdy,
	output dltq_pkg::entry_t  ent,
	output logic              keep,
	output logic              head_nz
);

	dltq_pkg::entry_t ent_q;
	dltq_pkg::entry_t nxt;
	logic [15:0]      due_dec;

	assign ent     = ent_q;
	assign keep    = ent_q.valid && (ent_q.rdy || ent_q.due <= cmd.delay);
	assign head_nz = ent_q.valid && !ent_q.rdy && prev_rdy && (ent_q.due != 16'd0);
	assign due_dec = ent_q.due - {15'd0, cmd.dec};

	always_comb begin
		nxt = ent_q;
		case (cmd.op)
			dltq_pkg::OP_INS: begin
				if (!keep) begin
					if (prev_keep) begin
						nxt.valid   = 1'b1;
						nxt.rdy     = 1'b0;
						nxt.task_id = cmd.task_id;
						nxt.period  = cmd.period;
						nxt.due     = cmd.delay;
					end else begin
						nxt = left;
					end
				end
			end
			dltq_pkg::OP_TICK: begin
				if (ent_q.valid && !ent_q.rdy) begin
					nxt.due = due_dec;
					nxt.rdy = (due_dec == 16'd0);
				end
			end
			dltq_pkg::OP_POP: nxt = right;
			default: nxt = ent_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			ent_q <= nxt;
		end
	end

endmodule

@@ hw/rtl/delta_list_task_timer_queue_top.sv @@
`timescale 1ns / 1ps
// Output: the result of each input transaction is registered when it is accepted.
// Throughput: one transaction per cycle unless m_tready holds the output; a dispatch
// of a periodic task then passes S_REINS, which puts the entry back into the cell row.
// Reset: arst_n clears every cell's valid bit, the state machine and the
// output valid flag; the queue is empty afterwards.
module delta_list_task_timer_queue_top #(
	parameter int SLOTS = dltq_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // action[1:0], task_id[9:2], delay[25:10], period[41:26]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // status[1:0], run_valid[2], run_task_id[10:3]
);

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_REINS = 2'b10
	} state_t;

	state_t             state_q;
	dltq_pkg::cmd_t     cmd;
	dltq_pkg::entry_t   ent [SLOTS];
	dltq_pkg::entry_t   empty_ent;
	logic [SLOTS-1:0]   keepv;
	logic [SLOTS-1:0]   nzv;
	logic [SLOTS-1:0]   vldv;
	logic [SLOTS-1:0]   rdyv;
	logic               acc;
	logic [1:0]         action;
	logic               full;
	logic               head_rdy;
	logic [1:0]         status;
	logic               run_valid;
	logic               out_valid_q;
	logic [15:0]        out_data_q;
	logic [7:0]         reins_task_q;
	logic [15:0]        reins_period_q;

	assign empty_ent = '0;
	assign action    = s_tdata[1:0];
	assign full      = ent[SLOTS-1].valid;
	assign head_rdy  = ent[0].valid && ent[0].rdy;
	assign s_tready  = (state_q == S_IDLE) && (!out_valid_q || m_tready);
	assign acc       = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	always_comb begin
		cmd.op      = dltq_pkg::OP_NONE;
		cmd.dec     = |nzv;
		cmd.task_id = s_tdata[9:2];
		cmd.period  = s_tdata[41:26];
		cmd.delay   = s_tdata[25:10];
		status      = dltq_pkg::ST_OK;
		run_valid   = 1'b0;
		if (state_q == S_REINS) begin
			cmd.op      = dltq_pkg::OP_INS;
			cmd.task_id = reins_task_q;
			cmd.period  = reins_period_q;
			cmd.delay   = reins_period_q;
		end else if (acc) begin
			case (action)
				dltq_pkg::ACT_ADD: begin
					if (full) status = dltq_pkg::ST_FULL;
					else cmd.op = dltq_pkg::OP_INS;
				end
				dltq_pkg::ACT_TICK: cmd.op = dltq_pkg::OP_TICK;
				dltq_pkg::ACT_DISPATCH: begin
					if (head_rdy) begin
						cmd.op    = dltq_pkg::OP_POP;
						run_valid = 1'b1;
					end else begin
						status = dltq_pkg::ST_EMPTY;
					end
				end
				default: cmd.op = dltq_pkg::OP_NONE;
			endcase
		end
	end

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		dltq_pkg::entry_t l_ent, r_ent;
		logic p_keep, p_rdy;
		if (i == 0) begin : g_first
			// the row start acts as a kept entry so an insert can land in cell 0
			assign l_ent  = empty_ent;
			assign p_keep = 1'b1;
			assign p_rdy  = 1'b1;
		end else begin : g_mid
			assign l_ent  = ent[i-1];
			assign p_keep = keepv[i-1];
			assign p_rdy  = ent[i-1].valid && ent[i-1].rdy;
		end
		if (i == SLOTS-1) begin : g_last
			assign r_ent = empty_ent;
		end else begin : g_nlast
			assign r_ent = ent[i+1];
		end
		dltq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.left      (l_ent),
			.right     (r_ent),
			.prev_keep (p_keep),
			.prev_rdy  (p_rdy),
			.ent       (ent[i]),
			.keep      (keepv[i]),
			.head_nz   (nzv[i])
		);
		assign vldv[i] = ent[i].valid;
		assign rdyv[i] = ent[i].valid && ent[i].rdy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			if (cmd.op == dltq_pkg::OP_POP && ent[0].period != 16'd0) state_q <= S_REINS;
			else state_q <= S_IDLE;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) out_data_q <= {5'd0, (run_valid ? ent[0].task_id : 8'd0), run_valid, status};
		if (cmd.op == dltq_pkg::OP_POP) begin
			reins_task_q   <= ent[0].task_id;
			reins_period_q <= ent[0].period;
		end
	end

	// occupied cells fill the row from cell 0 without gaps
	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		(vldv & (vldv + SLOTS'(1))) == '0)
		else $error("cell row has a gap");

	// ready entries always lead the row
	a_rdy_first: assert property (@(posedge clk) disable iff (!arst_n)
		(rdyv & (rdyv + SLOTS'(1))) == '0)
		else $error("ready entry behind a pending one");

	a_reins_src: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_REINS |-> $past(cmd.op == dltq_pkg::OP_POP))
		else $error("re-insert without a dispatch");

	a_no_acc_reins: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_REINS |-> !s_tready)
		else $error("input taken during re-insert");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;

	localparam int NSLOT = dltq_pkg::SLOTS_DEF;
	localparam logic [4:0] NIL = 5'(NSLOT);
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [7:0] run_id;
		logic       run_valid;
		logic [1:0] status;
	} run_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // action[1:0], task_id[9:2], delay[25:10], period[41:26]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // status[1:0], run_valid[2], run_task_id[10:3]

	delta_list_task_timer_queue_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// scheduler shadow state
	logic [7:0]  sh_task [NSLOT];
	logic [15:0] sh_delta [NSLOT];
	logic [15:0] sh_period [NSLOT];
	logic [4:0]  sh_link [NSLOT];
	bit          sh_used [NSLOT];
	logic [4:0]  pend_head, rdy_head, rdy_tail;

	run_result_t pending_results[$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_off = 0;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("delta_list_task_timer_queue_top test failed");
			$finish;
		end
	end

	function automatic void sched_insert(logic [4:0] s, int unsigned dly);
		logic [4:0] prev;
		logic [4:0] cur;
		int steps;
		prev = NIL;
		cur = pend_head;
		steps = 0;
		while (cur < NIL && steps < NSLOT && dly >= sh_delta[cur]) begin
			dly -= sh_delta[cur];
			prev = cur;
			cur = sh_link[cur];
			steps++;
		end
		sh_delta[s] = 16'(dly);
		sh_link[s] = cur;
		if (cur < NIL) sh_delta[cur] = 16'(sh_delta[cur] - dly);
		if (prev < NIL) sh_link[prev] = s;
		else pend_head = s;
	endfunction

	function automatic run_result_t sched_step(logic [1:0] act, logic [7:0] id,
			logic [15:0] dly, logic [15:0] per);
		run_result_t r;
		logic [4:0] s;
		int steps;
		r = '0;
		s = NIL;
		steps = 0;
		if (act == dltq_pkg::ACT_ADD) begin
			for (int i = NSLOT - 1; i >= 0; i--)
				if (!sh_used[i]) s = 5'(i);
			if (s == NIL) begin
				r.status = dltq_pkg::ST_FULL;
			end else begin
				sh_used[s] = 1'b1;
				sh_task[s] = id;
				sh_period[s] = per;
				sched_insert(s, dly);
			end
		end else if (act == dltq_pkg::ACT_TICK) begin
			if (pend_head < NIL) begin
				if (sh_delta[pend_head] > 0) sh_delta[pend_head] = sh_delta[pend_head] - 16'd1;
				// move every leading zero-delta entry to the ready fifo
				while (pend_head < NIL && steps < NSLOT && sh_delta[pend_head] == 0) begin
					s = pend_head;
					pend_head = sh_link[s];
					sh_link[s] = NIL;
					if (rdy_tail < NIL) sh_link[rdy_tail] = s;
					else rdy_head = s;
					rdy_tail = s;
					steps++;
				end
			end
		end else if (act == dltq_pkg::ACT_DISPATCH) begin
			if (rdy_head == NIL) begin
				r.status = dltq_pkg::ST_EMPTY;
			end else begin
				s = rdy_head;
				rdy_head = sh_link[s];
				if (rdy_head == NIL) rdy_tail = NIL;
				r.run_valid = 1'b1;
				r.run_id = sh_task[s];
				if (sh_period[s] != 0) sched_insert(s, sh_period[s]);
				else sh_used[s] = 1'b0;
			end
		end
		return r;
	endfunction

	task automatic send_item(logic [1:0] act, logic [7:0] id, logic [15:0] dly,
			logic [15:0] per);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, per, dly, id, act};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(sched_step(act, id, dly, per));
		@(negedge clk);
	endtask

	// receiver: random stalls plus an optional long hold-off
	always @(negedge clk) begin
		if (hold_off > 0) begin
			m_tready <= 1'b0;
			hold_off <= hold_off - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		run_result_t got;
		run_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = run_result_t'(m_tdata[10:0]);
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
					errors++;
				end
				if (got.run_valid !== want.run_valid) begin
					$display("%0t: run_valid expected %0d actual %0d", $time,
						want.run_valid, got.run_valid);
					errors++;
				end
				if (got.run_id !== want.run_id) begin
					$display("%0t: run_task_id expected %0d actual %0d", $time,
						want.run_id, got.run_id);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		send_item(dltq_pkg::ACT_DISPATCH, 8'd0, 16'd0, 16'd0);        // nothing ready
		send_item(dltq_pkg::ACT_TICK, 8'd0, 16'd0, 16'd0);            // nothing pending
		send_item(dltq_pkg::ACT_ADD, 8'd255, 16'd0, 16'd65535);       // delay zero, max period
		send_item(dltq_pkg::ACT_ADD, 8'd0, 16'd1, 16'd0);
		send_item(dltq_pkg::ACT_ADD, 8'd17, 16'd1, 16'd2);            // same due tick: after id 0
		send_item(dltq_pkg::ACT_ADD, 8'd90, 16'd65535, 16'd0);        // never falls due
		send_item(dltq_pkg::ACT_ADD, 8'd33, 16'd3, 16'd0);
		send_item(dltq_pkg::ACT_TICK, 8'd0, 16'd0, 16'd0);
		send_item(dltq_pkg::ACT_DISPATCH, 8'd0, 16'd0, 16'd0);
		send_item(dltq_pkg::ACT_TICK, 8'd0, 16'd0, 16'd0);
		send_item(dltq_pkg::ACT_DISPATCH, 8'd0, 16'd0, 16'd0);
		send_item(dltq_pkg::ACT_DISPATCH, 8'd0, 16'd0, 16'd0);
		send_item(dltq_pkg::ACT_DISPATCH, 8'd0, 16'd0, 16'd0);
		send_item(dltq_pkg::ACT_TICK, 8'd0, 16'd0, 16'd0);
		send_item(dltq_pkg::ACT_TICK, 8'd0, 16'd0, 16'd0);
		send_item(dltq_pkg::ACT_DISPATCH, 8'd0, 16'd0, 16'd0);
		send_item(dltq_pkg::ACT_DISPATCH, 8'd0, 16'd0, 16'd0);
		send_item(dltq_pkg::ACT_TICK, 8'd0, 16'd0, 16'd0);
		send_item(dltq_pkg::ACT_DISPATCH, 8'd0, 16'd0, 16'd0);
		send_item(dltq_pkg::ACT_DISPATCH, 8'd0, 16'd0, 16'd0);
	endtask

	task automatic test_full_table();
		// fill every free slot and keep adding past full, then tick and dispatch NSLOT times
		for (int i = 0; i < NSLOT + 1; i++)
			send_item(dltq_pkg::ACT_ADD, 8'($urandom_range(255)), 16'd0, 16'd0);
		send_item(dltq_pkg::ACT_TICK, 8'd0, 16'd0, 16'd0);
		for (int i = 0; i < NSLOT; i++)
			send_item(dltq_pkg::ACT_DISPATCH, 8'd0, 16'd0, 16'd0);
	endtask

	task automatic random_item();
		int pick;
		logic [15:0] dly;
		logic [15:0] per;
		pick = $urandom_range(99);
		dly = ($urandom_range(19) == 0) ? 16'($urandom_range(40)) : 16'($urandom_range(5));
		per = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom_range(6));
		if (pick < 35) send_item(dltq_pkg::ACT_ADD, 8'($urandom), dly, per);
		else if (pick < 70)
			send_item(dltq_pkg::ACT_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
		else send_item(dltq_pkg::ACT_DISPATCH, 8'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic test_random(int n, int s_pct, int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		repeat (n) random_item();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off = 300;
		repeat (40) random_item();
	endtask

	initial begin
		int waited;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		for (int i = 0; i < NSLOT; i++) begin
			sh_used[i] = 1'b0;
			sh_link[i] = NIL;
		end
		pend_head = NIL;
		rdy_head = NIL;
		rdy_tail = NIL;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_full_table();
		test_random(360, 21, 47);
		test_random(360, 47, 21);
		test_backpressure();
		test_random(360, 0, 0);
		s_tvalid <= 1'b0;

		waited = 0;
		while (pending_results.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("delta_list_task_timer_queue_top test passed");
		else
			$display("delta_list_task_timer_queue_top test failed");
		$finish;
	end

endmodule
